[hw/rtl/rcac_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcac_pkg
// Types, register map and constants of the radio command arming conditioner.
// ----------------------------------------------------------------------------
package rcac_pkg;

	// register map, byte address 4*index
	localparam int unsigned NUM_REGS  = 8;
	localparam int unsigned ADDR_W    = 5;
	localparam int unsigned IDX_W     = 3;
	localparam int unsigned PDATA_W   = 32;

	localparam logic [IDX_W-1:0] REG_LOW_VOLTAGE_WARNING   = 3'd0;
	localparam logic [IDX_W-1:0] REG_NORMAL_THROTTLE_LIMIT = 3'd1;
	localparam logic [IDX_W-1:0] REG_TRIM_ROLL             = 3'd2;
	localparam logic [IDX_W-1:0] REG_TRIM_PITCH            = 3'd3;
	localparam logic [IDX_W-1:0] REG_TRIM_YAW              = 3'd4;
	localparam logic [IDX_W-1:0] REG_TRIM_THROTTLE         = 3'd5;
	localparam logic [IDX_W-1:0] REG_TILT_GAIN             = 3'd6;
	localparam logic [IDX_W-1:0] REG_THROTTLE_DEADBAND     = 3'd7;

	// register reset values
	localparam logic [15:0] RST_LOW_VOLTAGE_WARNING   = 16'd10000;
	localparam logic [15:0] RST_NORMAL_THROTTLE_LIMIT = 16'd52429;
	localparam logic [14:0] RST_TRIM_ROLL             = 15'd3000;
	localparam logic [14:0] RST_TRIM_PITCH            = 15'd3000;
	localparam logic [14:0] RST_TRIM_YAW              = 15'd3000;
	localparam logic [14:0] RST_TRIM_THROTTLE         = 15'd2000;
	localparam logic [7:0]  RST_TILT_GAIN             = 8'd1;
	localparam logic [11:0] RST_THROTTLE_DEADBAND     = 12'd40;

	// fixed constants
	localparam logic signed [15:0] ARM_HIGH_OFFSET = 16'sd1000;
	localparam logic [15:0]        LOW_LIMIT_Q16   = 16'd45875;  // 0.7 in Q16, truncated
	localparam logic [16:0]        HYSTERESIS_MV   = 17'd500;
	localparam logic signed [15:0] YAW_DEAD_ZONE   = 16'sd50;
	localparam int unsigned        RATE_YAW_SHIFT  = 4;

	// flight modes
	localparam logic [1:0] FMODE_TILT     = 2'd0;
	localparam logic [1:0] FMODE_RATE     = 2'd1;
	localparam logic [1:0] FMODE_POSITION = 2'd2;
	localparam logic [1:0] FMODE_COMPASS  = 2'd3;

	// motor modes
	localparam logic [1:0] MOTOR_STABILIZE  = 2'd0;
	localparam logic [1:0] MOTOR_CALIBRATE  = 2'd1;
	localparam logic [1:0] MOTOR_IDLE       = 2'd2;
	localparam logic [1:0] MOTOR_ARMED_LOW  = 2'd3;

	typedef enum logic [1:0] {
		ARM_WAIT_HIGH = 2'd0,
		ARM_WAIT_LOW  = 2'd1,
		ARM_ARMED     = 2'd2
	} arm_state_t;

	typedef struct packed {
		logic [15:0] battery_mv;
		logic        rx_live;
		logic        calibrated;
		logic [1:0]  fly_mode;
		logic [14:0] pulse_roll;
		logic [14:0] pulse_pitch;
		logic [14:0] pulse_yaw;
		logic [14:0] pulse_throttle;
	} frame_t;

	typedef struct packed {
		logic [1:0]         motor_mode;
		logic               setpoints_valid;
		logic signed [15:0] roll_setpoint;
		logic signed [15:0] pitch_setpoint;
		logic signed [15:0] yaw_setpoint;
		logic signed [15:0] throttle_command;
	} cmd_t;

endpackage

[hw/rtl/rc_command_arming_conditioner_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_command_arming_conditioner_top
// Conditions one radio frame per request: battery throttle limit with
// hysteresis, three-step arming and tilt/rate setpoints.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                | payload
//  frame    | in        | frame_valid, frame_stall | frame (frame_t)
//  cmd      | out       | cmd_valid, cmd_stall     | cmd (cmd_t)
//  apb      | in/out    | psel, penable, pready    | paddr, pwdata, prdata
//
//  a frame is registered on acceptance and its command then enters the output
//  register; one frame per cycle sustained while cmd_stall is low. the throttle
//  limit and arming step update as a frame moves from the input register to
//  the output register. a stalled output holds the input register, which then
//  stalls the frame channel. reset restores every configuration and state
//  register to its default and leaves both stages empty.
// ----------------------------------------------------------------------------
module rc_command_arming_conditioner_top
	import rcac_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               frame_valid,
	output logic               frame_stall,
	input  frame_t             frame,
	output logic               cmd_valid,
	input  logic               cmd_stall,
	output cmd_t               cmd,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	// configuration registers
	logic [15:0] low_voltage_warning_q;
	logic [15:0] normal_throttle_limit_q;
	logic [14:0] trim_roll_q;
	logic [14:0] trim_pitch_q;
	logic [14:0] trim_yaw_q;
	logic [14:0] trim_throttle_q;
	logic [7:0]  tilt_gain_q;
	logic [11:0] throttle_deadband_q;

	logic [IDX_W-1:0] reg_idx;
	logic             reg_wr;

	// state
	logic [15:0] active_limit_q;
	arm_state_t  arm_q;
	arm_state_t  arm_next;

	// pipeline
	logic   valid_s1;
	frame_t frame_s1;
	logic   advance;
	cmd_t   cmd_next;

	// datapath
	logic [15:0]        limit_next;
	logic signed [15:0] thr_defl;
	logic signed [32:0] thr_prod;
	logic signed [15:0] dthr;
	logic signed [15:0] m_thr;
	logic [14:0]        m_roll;
	logic [14:0]        m_pitch;
	logic [14:0]        m_yaw;
	logic [15:0]        d_roll;
	logic [15:0]        d_pitch;
	logic signed [15:0] d_yaw;
	logic [23:0]        roll_prod;
	logic [23:0]        pitch_prod;
	logic signed [15:0] yaw_dz;
	logic signed [15:0] yaw_out;
	logic signed [15:0] deadband_s;
	logic               thr_low;
	logic [1:0]         mode;
	logic               sp_valid;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign reg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_voltage_warning_q   <= RST_LOW_VOLTAGE_WARNING;
			normal_throttle_limit_q <= RST_NORMAL_THROTTLE_LIMIT;
			trim_roll_q             <= RST_TRIM_ROLL;
			trim_pitch_q            <= RST_TRIM_PITCH;
			trim_yaw_q              <= RST_TRIM_YAW;
			trim_throttle_q         <= RST_TRIM_THROTTLE;
			tilt_gain_q             <= RST_TILT_GAIN;
			throttle_deadband_q     <= RST_THROTTLE_DEADBAND;
		end else if (reg_wr) begin
			unique case (reg_idx)
				REG_LOW_VOLTAGE_WARNING:   low_voltage_warning_q   <= pwdata[15:0];
				REG_NORMAL_THROTTLE_LIMIT: normal_throttle_limit_q <= pwdata[15:0];
				REG_TRIM_ROLL:             trim_roll_q             <= pwdata[14:0];
				REG_TRIM_PITCH:            trim_pitch_q            <= pwdata[14:0];
				REG_TRIM_YAW:              trim_yaw_q              <= pwdata[14:0];
				REG_TRIM_THROTTLE:         trim_throttle_q         <= pwdata[14:0];
				REG_TILT_GAIN:             tilt_gain_q             <= pwdata[7:0];
				REG_THROTTLE_DEADBAND:     throttle_deadband_q     <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_LOW_VOLTAGE_WARNING:   prdata[15:0] = low_voltage_warning_q;
			REG_NORMAL_THROTTLE_LIMIT: prdata[15:0] = normal_throttle_limit_q;
			REG_TRIM_ROLL:             prdata[14:0] = trim_roll_q;
			REG_TRIM_PITCH:            prdata[14:0] = trim_pitch_q;
			REG_TRIM_YAW:              prdata[14:0] = trim_yaw_q;
			REG_TRIM_THROTTLE:         prdata[14:0] = trim_throttle_q;
			REG_TILT_GAIN:             prdata[7:0]  = tilt_gain_q;
			REG_THROTTLE_DEADBAND:     prdata[11:0] = throttle_deadband_q;
			default: prdata = '0;
		endcase
	end

	// handshake: output register frees when empty or taken this cycle
	assign advance     = valid_s1 && (!cmd_valid || !cmd_stall);
	assign frame_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!frame_stall) begin
			valid_s1 <= frame_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_valid && !frame_stall) begin
			frame_s1 <= frame;
		end
	end

	// battery hysteresis, threshold computed one bit wider so it cannot wrap
	always_comb begin
		priority if (frame_s1.battery_mv < low_voltage_warning_q) begin
			limit_next = LOW_LIMIT_Q16;
		end else if ({1'b0, frame_s1.battery_mv} >
				({1'b0, low_voltage_warning_q} + HYSTERESIS_MV)) begin
			limit_next = normal_throttle_limit_q;
		end else begin
			limit_next = active_limit_q;
		end
	end

	// throttle scaling: upper half of unsigned limit times signed deflection
	assign thr_defl = $signed({1'b0, frame_s1.pulse_throttle} - {1'b0, trim_throttle_q});
	assign thr_prod = $signed({1'b0, limit_next}) * thr_defl;
	assign dthr     = frame_s1.rx_live ? thr_prod[31:16] : 16'sd0;
	assign m_thr    = dthr + $signed({1'b0, trim_throttle_q});

	assign m_roll  = frame_s1.rx_live ? frame_s1.pulse_roll  : trim_roll_q;
	assign m_pitch = frame_s1.rx_live ? frame_s1.pulse_pitch : trim_pitch_q;
	assign m_yaw   = frame_s1.rx_live ? frame_s1.pulse_yaw   : trim_yaw_q;

	assign deadband_s = $signed({4'b0000, throttle_deadband_q});
	assign thr_low    = dthr < deadband_s;

	// arming sequence: next step
	always_comb begin
		arm_next = arm_q;
		if (frame_s1.calibrated) begin
			unique case (arm_q)
				ARM_WAIT_HIGH: if (dthr > ARM_HIGH_OFFSET) arm_next = ARM_WAIT_LOW;
				ARM_WAIT_LOW:  if (thr_low) arm_next = ARM_ARMED;
				ARM_ARMED:     arm_next = ARM_ARMED;
				default:       arm_next = arm_q;
			endcase
		end
	end

	// arming sequence: motor mode
	always_comb begin
		if (!frame_s1.calibrated) begin
			mode = MOTOR_CALIBRATE;
		end else begin
			unique case (arm_q)
				ARM_WAIT_HIGH, ARM_WAIT_LOW: mode = MOTOR_IDLE;
				default: mode = thr_low ? MOTOR_ARMED_LOW : MOTOR_STABILIZE;
			endcase
		end
	end

	assign sp_valid = (mode == MOTOR_STABILIZE) &&
		((frame_s1.fly_mode == FMODE_TILT) || (frame_s1.fly_mode == FMODE_RATE));

	assign d_roll     = {1'b0, m_roll}  - {1'b0, trim_roll_q};
	assign d_pitch    = {1'b0, m_pitch} - {1'b0, trim_pitch_q};
	assign d_yaw      = $signed({1'b0, m_yaw} - {1'b0, trim_yaw_q});
	assign roll_prod  = d_roll  * tilt_gain_q;
	assign pitch_prod = d_pitch * tilt_gain_q;

	always_comb begin
		priority if (d_yaw >= YAW_DEAD_ZONE) begin
			yaw_dz = d_yaw - YAW_DEAD_ZONE;
		end else if (d_yaw <= -YAW_DEAD_ZONE) begin
			yaw_dz = d_yaw + YAW_DEAD_ZONE;
		end else begin
			yaw_dz = 16'sd0;
		end
	end

	assign yaw_out = (frame_s1.fly_mode == FMODE_RATE) ? (yaw_dz <<< RATE_YAW_SHIFT) : yaw_dz;

	always_comb begin
		cmd_next                 = '0;
		cmd_next.motor_mode      = mode;
		cmd_next.setpoints_valid = sp_valid;
		if (sp_valid) begin
			cmd_next.roll_setpoint    = $signed(roll_prod[15:0]);
			cmd_next.pitch_setpoint   = $signed(pitch_prod[15:0]);
			cmd_next.yaw_setpoint     = yaw_out;
			cmd_next.throttle_command = m_thr;
		end
	end

	// state and output register update as the frame moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_limit_q <= RST_NORMAL_THROTTLE_LIMIT;
			arm_q          <= ARM_WAIT_HIGH;
			cmd_valid      <= 1'b0;
		end else begin
			if (advance) begin
				active_limit_q <= limit_next;
				arm_q          <= arm_next;
				cmd_valid      <= 1'b1;
			end else if (!cmd_stall) begin
				cmd_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cmd <= cmd_next;
		end
	end

endmodule

[bench/rcac_cmd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcac_cmd_checker
// Watches the frame, command and register ports of the radio command arming
// conditioner. Each accepted frame is run through a local copy of the
// throttle limit, arming and setpoint logic, and each accepted command is
// compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module rcac_cmd_checker
	import rcac_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              frame_valid,
	input  logic              frame_stall,
	input  frame_t            frame,
	input  logic              cmd_valid,
	input  logic              cmd_stall,
	input  cmd_t              cmd,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output int                mismatches,
	output int                pending
);

	logic [15:0] warn_mv;
	logic [15:0] normal_limit;
	logic [15:0] thr_limit;
	logic [14:0] trim_roll;
	logic [14:0] trim_pitch;
	logic [14:0] trim_yaw;
	logic [14:0] trim_thr;
	logic [7:0]  gain;
	logic [11:0] deadband;
	arm_state_t  arm;

	cmd_t expected_cmds[$];
	int   mismatch_count;

	// advances the limit and arming state by one frame, returns its command
	function automatic cmd_t condition_frame(input frame_t f);
		logic signed [15:0] defl;
		logic signed [15:0] hi;
		logic signed [15:0] m_thr;
		logic signed [15:0] dthr;
		logic signed [15:0] dr;
		logic signed [15:0] dp;
		logic signed [15:0] dy;
		longint prod;
		int m_roll;
		int m_pitch;
		int m_yaw;
		int yaw_i;
		cmd_t c;
		c = '0;

		// hysteresis: threshold is taken without wrap
		if (f.battery_mv < warn_mv)
			thr_limit = LOW_LIMIT_Q16;
		else if (int'(f.battery_mv) > int'(warn_mv) + int'(HYSTERESIS_MV))
			thr_limit = normal_limit;

		if (f.rx_live) begin
			defl = 16'(int'(f.pulse_throttle) - int'(trim_thr));
			prod = longint'(thr_limit) * longint'(defl);
			hi = prod[31:16];
			m_thr = hi + $signed({1'b0, trim_thr});
			m_roll = f.pulse_roll;
			m_pitch = f.pulse_pitch;
			m_yaw = f.pulse_yaw;
		end else begin
			m_thr = $signed({1'b0, trim_thr});
			m_roll = trim_roll;
			m_pitch = trim_pitch;
			m_yaw = trim_yaw;
		end

		dthr = m_thr - $signed({1'b0, trim_thr});

		if (!f.calibrated) begin
			c.motor_mode = MOTOR_CALIBRATE;
		end else if (arm != ARM_ARMED) begin
			if (arm == ARM_WAIT_HIGH) begin
				if (dthr > ARM_HIGH_OFFSET)
					arm = ARM_WAIT_LOW;
			end else if (int'(dthr) < int'(deadband)) begin
				arm = ARM_ARMED;
			end
			c.motor_mode = MOTOR_IDLE;
		end else if (int'(dthr) < int'(deadband)) begin
			c.motor_mode = MOTOR_ARMED_LOW;
		end else begin
			c.motor_mode = MOTOR_STABILIZE;
		end

		if (c.motor_mode == MOTOR_STABILIZE &&
				(f.fly_mode == FMODE_TILT || f.fly_mode == FMODE_RATE)) begin
			dr = 16'(m_roll - int'(trim_roll));
			dp = 16'(m_pitch - int'(trim_pitch));
			dy = 16'(m_yaw - int'(trim_yaw));
			c.setpoints_valid = 1'b1;
			c.roll_setpoint = 16'(int'(dr) * int'(gain));
			c.pitch_setpoint = 16'(int'(dp) * int'(gain));
			yaw_i = dy;
			if (yaw_i >= int'(YAW_DEAD_ZONE))
				yaw_i = yaw_i - int'(YAW_DEAD_ZONE);
			else if (yaw_i <= -int'(YAW_DEAD_ZONE))
				yaw_i = yaw_i + int'(YAW_DEAD_ZONE);
			else
				yaw_i = 0;
			if (f.fly_mode == FMODE_RATE)
				yaw_i = yaw_i << RATE_YAW_SHIFT;
			c.yaw_setpoint = 16'(yaw_i);
			c.throttle_command = m_thr;
		end
		return c;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		cmd_t want;
		if (!arst_n) begin
			warn_mv = RST_LOW_VOLTAGE_WARNING;
			normal_limit = RST_NORMAL_THROTTLE_LIMIT;
			trim_roll = RST_TRIM_ROLL;
			trim_pitch = RST_TRIM_PITCH;
			trim_yaw = RST_TRIM_YAW;
			trim_thr = RST_TRIM_THROTTLE;
			gain = RST_TILT_GAIN;
			deadband = RST_THROTTLE_DEADBAND;
			thr_limit = RST_NORMAL_THROTTLE_LIMIT;
			arm = ARM_WAIT_HIGH;
			mismatch_count = 0;
			expected_cmds.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:2])
					REG_LOW_VOLTAGE_WARNING:   warn_mv = pwdata[15:0];
					REG_NORMAL_THROTTLE_LIMIT: normal_limit = pwdata[15:0];
					REG_TRIM_ROLL:             trim_roll = pwdata[14:0];
					REG_TRIM_PITCH:            trim_pitch = pwdata[14:0];
					REG_TRIM_YAW:              trim_yaw = pwdata[14:0];
					REG_TRIM_THROTTLE:         trim_thr = pwdata[14:0];
					REG_TILT_GAIN:             gain = pwdata[7:0];
					REG_THROTTLE_DEADBAND:     deadband = pwdata[11:0];
					default: ;
				endcase
			end
			if (frame_valid && !frame_stall)
				expected_cmds.push_back(condition_frame(frame));
			if (cmd_valid && !cmd_stall) begin
				if (expected_cmds.size() == 0) begin
					$error("command accepted with no frame outstanding");
					mismatch_count++;
				end else begin
					want = expected_cmds.pop_front();
					check_field("motor_mode", want.motor_mode, cmd.motor_mode);
					check_field("setpoints_valid", want.setpoints_valid, cmd.setpoints_valid);
					check_field("roll_setpoint", want.roll_setpoint, cmd.roll_setpoint);
					check_field("pitch_setpoint", want.pitch_setpoint, cmd.pitch_setpoint);
					check_field("yaw_setpoint", want.yaw_setpoint, cmd.yaw_setpoint);
					check_field("throttle_command", want.throttle_command,
						cmd.throttle_command);
				end
			end
		end
		mismatches <= mismatch_count;
		pending <= expected_cmds.size();
	end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the radio command arming conditioner: a directed walk through
// arming, hysteresis and setpoint corners, then random frames under several
// register settings with bursty requests and a stalling command receiver.
// ----------------------------------------------------------------------------
module tb_top
	import rcac_pkg::*;
();

	localparam int NUM_PHASES = 8;
	localparam int PHASE_ITEMS = 104;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic               frame_valid;
	logic               frame_stall;
	frame_t             frame;
	logic               cmd_valid;
	logic               cmd_stall;
	cmd_t               cmd;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [ADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	int mismatches;
	int pending;

	logic        hold_off_req = 1'b0;
	logic [31:0] cfg [NUM_REGS];
	int          burst_left = 0;

	always #6 clk = ~clk;

	rc_command_arming_conditioner_top i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_valid (frame_valid),
		.frame_stall (frame_stall),
		.frame       (frame),
		.cmd_valid   (cmd_valid),
		.cmd_stall   (cmd_stall),
		.cmd         (cmd),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	rcac_cmd_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_valid (frame_valid),
		.frame_stall (frame_stall),
		.frame       (frame),
		.cmd_valid   (cmd_valid),
		.cmd_stall   (cmd_stall),
		.cmd         (cmd),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.mismatches  (mismatches),
		.pending     (pending)
	);

	initial begin
		#5_000_000;
		$display("rc_command_arming_conditioner_top: mismatch");
		$finish;
	end

	// command receiver: free runs, random stalls and one long hold-off
	initial begin
		int n;
		int pct;
		int kind;
		bit held;
		held = 1'b0;
		cmd_stall <= 1'b0;
		forever begin
			if (hold_off_req && !held) begin
				held = 1'b1;
				repeat (150) begin
					@(posedge clk);
					cmd_stall <= 1'b1;
				end
			end else begin
				kind = $urandom_range(0, 9);
				n = $urandom_range(5, 70);
				pct = $urandom_range(10, 70);
				repeat (n) begin
					@(posedge clk);
					if (kind < 4)
						cmd_stall <= 1'b0;
					else if (kind < 9)
						cmd_stall <= ($urandom_range(0, 99) < pct);
					else
						cmd_stall <= 1'b1;
				end
			end
		end
	end

	function automatic logic [31:0] reg_max(input logic [IDX_W-1:0] idx);
		case (idx)
			REG_LOW_VOLTAGE_WARNING, REG_NORMAL_THROTTLE_LIMIT: return 32'd65535;
			REG_TILT_GAIN:                                      return 32'd255;
			REG_THROTTLE_DEADBAND:                              return 32'd4095;
			default:                                            return 32'd32767;
		endcase
	endfunction

	function automatic frame_t build_frame(input int batt, input bit radio, input bit cal,
			input logic [1:0] fm, input int roll, input int pitch, input int yaw,
			input int thr);
		frame_t f;
		f.battery_mv = 16'(batt);
		f.rx_live = radio;
		f.calibrated = cal;
		f.fly_mode = fm;
		f.pulse_roll = 15'(roll);
		f.pulse_pitch = 15'(pitch);
		f.pulse_yaw = 15'(yaw);
		f.pulse_throttle = 15'(thr);
		return f;
	endfunction

	function automatic logic [14:0] near_trim(input logic [31:0] trim, input int spread);
		return 15'(int'(trim) + int'($urandom_range(0, 2 * spread)) - spread);
	endfunction

	// mostly frames around the current trims and warning level
	function automatic frame_t random_frame();
		frame_t f;
		if ($urandom_range(0, 1))
			f.battery_mv = 16'(int'(cfg[REG_LOW_VOLTAGE_WARNING])
				+ int'($urandom_range(0, 2000)) - 700);
		else
			f.battery_mv = 16'($urandom);
		f.rx_live = ($urandom_range(0, 6) != 0);
		f.calibrated = ($urandom_range(0, 9) != 0);
		f.fly_mode = 2'($urandom);
		f.pulse_roll = ($urandom_range(0, 2) == 0) ? 15'($urandom)
			: near_trim(cfg[REG_TRIM_ROLL], 400);
		f.pulse_pitch = ($urandom_range(0, 2) == 0) ? 15'($urandom)
			: near_trim(cfg[REG_TRIM_PITCH], 400);
		f.pulse_yaw = ($urandom_range(0, 2) == 0) ? 15'($urandom)
			: near_trim(cfg[REG_TRIM_YAW], 120);
		f.pulse_throttle = ($urandom_range(0, 3) == 0) ? 15'($urandom)
			: 15'(int'(cfg[REG_TRIM_THROTTLE]) + int'($urandom_range(0, 9000)) - 3000);
		return f;
	endfunction

	// offers one request and holds it until accepted, then maybe idles
	task automatic send_frame(input frame_t f);
		int gap;
		frame <= f;
		frame_valid <= 1'b1;
		do @(posedge clk); while (frame_stall);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 20);
			if (gap > 0) begin
				frame_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic drain();
		frame_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_config();
		for (int r = 0; r < NUM_REGS; r++) begin
			psel <= 1'b1;
			penable <= 1'b0;
			pwrite <= 1'b1;
			paddr <= ADDR_W'(r * 4);
			pwdata <= cfg[r];
			@(posedge clk);
			penable <= 1'b1;
			do @(posedge clk); while (!pready);
		end
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	initial begin
		frame_valid <= 1'b0;
		frame <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: arming walk, deadband edges, hysteresis edges
		send_frame(build_frame(0, 1, 0, FMODE_TILT, 0, 0, 0, 0));
		send_frame(build_frame(65535, 1, 0, FMODE_COMPASS, 32767, 32767, 32767, 32767));
		send_frame(build_frame(12000, 0, 1, FMODE_TILT, 32767, 0, 32767, 32767));
		send_frame(build_frame(12000, 1, 1, FMODE_TILT, 3000, 3000, 3000, 3000));
		send_frame(build_frame(12000, 1, 1, FMODE_RATE, 3000, 3000, 3000, 4000));
		send_frame(build_frame(12000, 1, 1, FMODE_TILT, 3000, 3000, 3000, 3000));
		send_frame(build_frame(12000, 1, 1, FMODE_TILT, 3000, 3000, 3000, 2000));
		send_frame(build_frame(12000, 1, 1, FMODE_TILT, 3000, 3000, 3000, 2040));
		send_frame(build_frame(12000, 1, 1, FMODE_TILT, 3100, 2900, 3049, 4000));
		send_frame(build_frame(12000, 1, 1, FMODE_RATE, 3100, 2900, 3050, 4000));
		send_frame(build_frame(12000, 1, 1, FMODE_RATE, 3100, 2900, 3051, 4000));
		send_frame(build_frame(12000, 1, 1, FMODE_TILT, 3100, 2900, 2950, 4000));
		send_frame(build_frame(12000, 1, 1, FMODE_RATE, 3100, 2900, 2949, 4000));
		send_frame(build_frame(12000, 1, 1, FMODE_POSITION, 3100, 2900, 2949, 4000));
		send_frame(build_frame(12000, 1, 1, FMODE_COMPASS, 3100, 2900, 2949, 4000));
		send_frame(build_frame(12000, 1, 1, FMODE_TILT, 0, 0, 0, 32767));
		send_frame(build_frame(12000, 1, 1, FMODE_RATE, 32767, 32767, 32767, 32767));
		send_frame(build_frame(9999, 1, 1, FMODE_TILT, 3000, 3000, 3000, 4000));
		send_frame(build_frame(10500, 1, 1, FMODE_TILT, 3000, 3000, 3000, 4000));
		send_frame(build_frame(10501, 1, 1, FMODE_TILT, 3000, 3000, 3000, 4000));
		send_frame(build_frame(10000, 1, 1, FMODE_TILT, 3000, 3000, 3000, 4000));
		send_frame(build_frame(12000, 1, 1, FMODE_TILT, 3000, 3000, 3000, 0));
		send_frame(build_frame(12000, 0, 1, FMODE_RATE, 0, 0, 0, 32767));
		send_frame(build_frame(12000, 1, 0, FMODE_RATE, 3100, 2900, 3100, 4000));

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			drain();
			for (int r = 0; r < NUM_REGS; r++) begin
				if (phase == 0)
					cfg[r] = '0;
				else if (phase == 1)
					cfg[r] = reg_max(r[IDX_W-1:0]);
				else
					cfg[r] = $urandom_range(0, reg_max(r[IDX_W-1:0]));
			end
			// keep most random settings able to leave the armed-low mode
			if (phase > 1) begin
				cfg[REG_NORMAL_THROTTLE_LIMIT] = $urandom_range(20000, 65535);
				cfg[REG_THROTTLE_DEADBAND] = $urandom_range(0, 600);
			end
			program_config();
			if (phase == 3)
				hold_off_req = 1'b1;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (phase == 2 && i == 50)
					drain();
				send_frame(random_frame());
			end
		end

		drain();
		if (mismatches == 0)
			$display("rc_command_arming_conditioner_top: match");
		else
			$display("rc_command_arming_conditioner_top: mismatch");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/rcac_pkg.sv
hw/rtl/rc_command_arming_conditioner_top.sv
bench/rcac_cmd_checker.sv
bench/tb_top.sv
